// ----- rtl/minimap_pixel_color_top_assert.svh -----
// ----------------------------------------------------------------------------
// minimap pixel color assertion macros
// concurrent checks clocked on clk, disabled while rst is high
// ----------------------------------------------------------------------------
`ifndef MINIMAP_PIXEL_COLOR_TOP_ASSERT_SVH
`define MINIMAP_PIXEL_COLOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// property holds at every edge
`define MMPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("minimap pixel color check failed");
// consequent holds in the cycle after the antecedent
`define MMPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("minimap pixel color sequence check failed");
`else
`define MMPC_ASSERT(lbl, prop)
`define MMPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/mmpc_pkg.sv -----
// ----------------------------------------------------------------------------
// mmpc_pkg
// shared widths, codes, colors and helper functions of the minimap colorer
// ----------------------------------------------------------------------------
`default_nettype none

package mmpc_pkg;

  // map geometry and fixed point
  localparam int MAP_ROWS  = 64;
  localparam int MAP_COLS  = 64;
  localparam int FRAC_BITS = 8;

  // field widths
  localparam int PIX_W      = 10;
  localparam int SIZE_W     = 11;
  localparam int UNIT_W     = 7;
  localparam int PLAYER_W   = 14;
  localparam int COUNT_W    = 7;
  localparam int CODE_W     = 2;
  localparam int LEN_W      = 7;
  localparam int IDX_W      = 6;
  localparam int COLOR_W    = 24;
  localparam int CLASS_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 14;

  // divider and position widths
  localparam int NUM_W         = PIX_W + FRAC_BITS;
  localparam int REM_W         = UNIT_W;
  localparam int POS_W         = NUM_W + 2;
  localparam int RC_W          = POS_W - 1 - FRAC_BITS;
  localparam int COL_CW        = 8;
  localparam int ROW_W         = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int TILE_DEPTH    = MAP_ROWS * MAP_COLS;
  localparam int TILE_AW       = (TILE_DEPTH > 1) ? $clog2(TILE_DEPTH) : 1;
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = (NUM_W + DIV_PER_STAGE - 1) / DIV_PER_STAGE;

  localparam int BORDER_PIX = 2;

  localparam logic [CODE_W-1:0] TILE_FLOOR = 2'd1;
  localparam logic [CODE_W-1:0] TILE_DOOR  = 2'd2;

  localparam logic [COLOR_W-1:0] COLOR_FLOOR  = 24'hffffff;
  localparam logic [COLOR_W-1:0] COLOR_DOOR   = 24'h00ff00;
  localparam logic [COLOR_W-1:0] COLOR_PLAYER = 24'hff0000;
  localparam logic [COLOR_W-1:0] COLOR_BORDER = 24'haaaaaa;
  localparam logic [COLOR_W-1:0] COLOR_BACK   = 24'h000000;

  typedef enum logic [1:0] {
    MODE_PIXEL  = 2'd0,
    MODE_CELL   = 2'd1,
    MODE_ROWLEN = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_PLAYER = 3'd0,
    CLASS_FLOOR  = 3'd1,
    CLASS_DOOR   = 3'd2,
    CLASS_BORDER = 3'd3,
    CLASS_BACK   = 3'd4
  } pixel_class_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_WIDTH  = 3'd0,
    REG_VIEW_HEIGHT = 3'd1,
    REG_CELL_PIXELS = 3'd2,
    REG_PLAYER_COL  = 3'd3,
    REG_PLAYER_ROW  = 3'd4,
    REG_ROW_COUNT   = 3'd5
  } cfg_reg_t;

  // word in flight through the divider stages
  typedef struct packed {
    mode_t              mode;
    logic               player_hit;
    logic               border_hit;
    logic               neg_x;
    logic               neg_y;
    logic [REM_W-1:0]   rem_x;
    logic [REM_W-1:0]   rem_y;
    logic [NUM_W-1:0]   num_x;
    logic [NUM_W-1:0]   num_y;
    logic [IDX_W-1:0]   map_row;
    logic [IDX_W-1:0]   map_col;
    logic [CODE_W-1:0]  cell_code;
    logic [LEN_W-1:0]   row_length;
  } div_item_t;

  // word at the memory access stage
  typedef struct packed {
    mode_t               mode;
    logic                player_hit;
    logic                border_hit;
    logic                cell_ok;
    logic                tile_wr_ok;
    logic                row_wr_ok;
    logic [COL_CW-1:0]   col_idx;
    logic [TILE_AW-1:0]  tile_addr;
    logic [ROW_W-1:0]    row_addr;
    logic [CODE_W-1:0]   cell_code;
    logic [LEN_W-1:0]    row_length;
  } mem_item_t;

  // word waiting on memory read data
  typedef struct packed {
    logic              player_hit;
    logic              border_hit;
    logic              cell_ok;
    logic [COL_CW-1:0] col_idx;
  } rd_item_t;

  // c-style halving, rounds toward zero
  function automatic logic signed [SIZE_W+1:0] half_trunc(input logic signed [SIZE_W+1:0] v);
    logic signed [SIZE_W+1:0] adj;
    adj = v + $signed({{(SIZE_W+1){1'b0}}, v[SIZE_W+1]});
    return adj >>> 1;
  endfunction

  // one restoring division step: returns {remainder, shifted dividend with quotient bit}
  function automatic logic [REM_W+NUM_W-1:0] div_step(input logic [REM_W-1:0] rem,
                                                      input logic [NUM_W-1:0] num,
                                                      input logic [REM_W-1:0] unit);
    logic [REM_W:0] trial;
    logic [REM_W:0] diff;
    trial = {rem, num[NUM_W-1]};
    diff  = trial - {1'b0, unit};
    if (trial >= {1'b0, unit}) begin
      return {diff[REM_W-1:0], num[NUM_W-2:0], 1'b1};
    end
    return {trial[REM_W-1:0], num[NUM_W-2:0], 1'b0};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mmpc_req_if.sv -----
// ----------------------------------------------------------------------------
// mmpc_req_if
// request channel: pixel queries and map load words
// ----------------------------------------------------------------------------
`default_nettype none

interface mmpc_req_if import mmpc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [PIX_W-1:0]   pix_x;
  logic [PIX_W-1:0]   pix_y;
  logic [IDX_W-1:0]   map_row;
  logic [IDX_W-1:0]   map_col;
  logic [CODE_W-1:0]  cell_code;
  logic [LEN_W-1:0]   row_length;

  modport source (
    output valid, mode, pix_x, pix_y, map_row, map_col, cell_code, row_length,
    input  ready
  );
  modport sink (
    input  valid, mode, pix_x, pix_y, map_row, map_col, cell_code, row_length,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/mmpc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// mmpc_rsp_if
// response channel: one color word per pixel query
// ----------------------------------------------------------------------------
`default_nettype none

interface mmpc_rsp_if import mmpc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  color;
  logic [CLASS_W-1:0]  pixel_class;

  modport source (output valid, color, pixel_class, input ready);
  modport sink   (input valid, color, pixel_class, output ready);
endinterface

`default_nettype wire

// ----- rtl/mmpc_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mmpc_cfg_if
// register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface mmpc_cfg_if import mmpc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/mmpc_ram.sv -----
// ----------------------------------------------------------------------------
// mmpc_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module mmpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/minimap_pixel_color_top.sv -----
// ----------------------------------------------------------------------------
// minimap_pixel_color_top: minimap pixel colorer, one word per cycle unless stalled
// pipeline: 10 stages, entry, six divider stages, position, read and color
// throughput: 1 word per cycle when not stalled; six 3-bit divider stages per axis set the depth
// reset: rst clears valid bits and config registers, data registers and map stores stay unknown
// ----------------------------------------------------------------------------
`default_nettype none

`include "minimap_pixel_color_top_assert.svh"

module minimap_pixel_color_top import mmpc_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  mmpc_cfg_if.sink  cfg,
  mmpc_req_if.sink  req,
  mmpc_rsp_if.source rsp
);

  // --------------------------------------------------------------------------
  // configuration registers, to be written by the user only while the pipe is empty; the block does not enforce it
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]   view_width;
  logic [SIZE_W-1:0]   view_height;
  logic [UNIT_W-1:0]   cell_pixels;
  logic [PLAYER_W-1:0] player_col_pos;
  logic [PLAYER_W-1:0] player_row_pos;
  logic [COUNT_W-1:0]  row_count;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width     <= SIZE_W'(200);
      view_height    <= SIZE_W'(200);
      cell_pixels    <= UNIT_W'(10);
      player_col_pos <= '0;
      player_row_pos <= '0;
      row_count      <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_VIEW_WIDTH:  view_width     <= cfg.data[SIZE_W-1:0];
        REG_VIEW_HEIGHT: view_height    <= cfg.data[SIZE_W-1:0];
        REG_CELL_PIXELS: cell_pixels    <= cfg.data[UNIT_W-1:0];
        REG_PLAYER_COL:  player_col_pos <= cfg.data[PLAYER_W-1:0];
        REG_PLAYER_ROW:  player_row_pos <= cfg.data[PLAYER_W-1:0];
        REG_ROW_COUNT:   row_count      <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline valid bits and stall chain
  // each stage takes a new word when it is empty or its word moves on
  // --------------------------------------------------------------------------
  logic [DIV_STAGES:0] dvld;
  logic [DIV_STAGES:0] dready;
  logic                p_vld;
  logic                p_ready;
  logic                r_vld;
  logic                r_ready;
  logic                res_vld;
  logic                o_ready;

  always_comb begin
    o_ready            = !res_vld || rsp.ready;
    r_ready            = !r_vld || o_ready;
    p_ready            = !p_vld || r_ready;
    dready[DIV_STAGES] = !dvld[DIV_STAGES] || p_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      dready[k] = !dvld[k] || dready[k+1];
    end
  end

  assign req.ready = dready[0];

  // --------------------------------------------------------------------------
  // entry stage: offsets from the view center, player square and border tests
  // --------------------------------------------------------------------------
  logic signed [SIZE_W:0]   dx;
  logic signed [SIZE_W:0]   dy;
  logic signed [SIZE_W:0]   dx_abs;
  logic signed [SIZE_W:0]   dy_abs;
  logic signed [SIZE_W+1:0] lo_x;
  logic signed [SIZE_W+1:0] lo_y;
  logic [SIZE_W-1:0]        hi_x;
  logic [SIZE_W-1:0]        hi_y;
  logic signed [SIZE_W:0]   lim_x;
  logic signed [SIZE_W:0]   lim_y;
  div_item_t                entry;

  always_comb begin
    dx = $signed({2'b00, req.pix_x}) - $signed({2'b00, view_width[SIZE_W-1:1]});
    dy = $signed({2'b00, req.pix_y}) - $signed({2'b00, view_height[SIZE_W-1:1]});
    dx_abs = dx[SIZE_W] ? -dx : dx;
    dy_abs = dy[SIZE_W] ? -dy : dy;

    // strict player square bounds with truncating halves
    lo_x = half_trunc($signed({2'b00, view_width}) -
                      $signed({{(SIZE_W+2-UNIT_W){1'b0}}, cell_pixels}));
    lo_y = half_trunc($signed({2'b00, view_height}) -
                      $signed({{(SIZE_W+2-UNIT_W){1'b0}}, cell_pixels}));
    hi_x = SIZE_W'(({1'b0, view_width} + {{(SIZE_W+1-UNIT_W){1'b0}}, cell_pixels}) >> 1);
    hi_y = SIZE_W'(({1'b0, view_height} + {{(SIZE_W+1-UNIT_W){1'b0}}, cell_pixels}) >> 1);

    // last column and row inside the border
    lim_x = $signed({1'b0, view_width}) - $signed((SIZE_W+1)'(BORDER_PIX + 1));
    lim_y = $signed({1'b0, view_height}) - $signed((SIZE_W+1)'(BORDER_PIX + 1));

    entry.mode       = mode_t'(req.mode);
    entry.player_hit = ($signed({3'b000, req.pix_y}) > lo_y) && ({1'b0, req.pix_y} < hi_y) &&
                       ($signed({3'b000, req.pix_x}) > lo_x) && ({1'b0, req.pix_x} < hi_x);
    entry.border_hit = (req.pix_x < PIX_W'(BORDER_PIX)) ||
                       ($signed({2'b00, req.pix_x}) > lim_x) ||
                       (req.pix_y < PIX_W'(BORDER_PIX)) ||
                       ($signed({2'b00, req.pix_y}) > lim_y);
    entry.neg_x      = dx[SIZE_W];
    entry.neg_y      = dy[SIZE_W];
    entry.rem_x      = '0;
    entry.rem_y      = '0;
    entry.num_x      = {dx_abs[PIX_W-1:0], {FRAC_BITS{1'b0}}};
    entry.num_y      = {dy_abs[PIX_W-1:0], {FRAC_BITS{1'b0}}};
    entry.map_row    = req.map_row;
    entry.map_col    = req.map_col;
    entry.cell_code  = req.cell_code;
    entry.row_length = req.row_length;
  end

  // --------------------------------------------------------------------------
  // divider stages: |offset| * 2^FRAC_BITS / cell_pixels, magnitude first,
  // sign applied afterwards so the quotient truncates toward zero
  // --------------------------------------------------------------------------
  div_item_t dstage [DIV_STAGES+1];
  div_item_t dnext  [DIV_STAGES+1];

  always_comb begin
    dnext[0] = entry;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      dnext[k] = dstage[k-1];
      for (int t = 0; t < DIV_PER_STAGE; t++) begin
        if ((k - 1) * DIV_PER_STAGE + t < NUM_W) begin
          {dnext[k].rem_x, dnext[k].num_x} =
            div_step(dnext[k].rem_x, dnext[k].num_x, cell_pixels);
          {dnext[k].rem_y, dnext[k].num_y} =
            div_step(dnext[k].rem_y, dnext[k].num_y, cell_pixels);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= DIV_STAGES; k++) begin
      if (dready[k]) begin
        dstage[k] <= dnext[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // position stage: add player position, range checks, memory addresses
  // --------------------------------------------------------------------------
  logic signed [POS_W-1:0] q_x;
  logic signed [POS_W-1:0] q_y;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic [RC_W-1:0]         col_full;
  logic [RC_W-1:0]         row_full;
  logic                    row_ok;
  logic                    col_ok;
  mem_item_t               p_next;
  mem_item_t               pst;

  always_comb begin
    q_x   = $signed({2'b00, dstage[DIV_STAGES].num_x});
    q_y   = $signed({2'b00, dstage[DIV_STAGES].num_y});
    pos_x = (dstage[DIV_STAGES].neg_x ? -q_x : q_x) + $signed(POS_W'(player_col_pos));
    pos_y = (dstage[DIV_STAGES].neg_y ? -q_y : q_y) + $signed(POS_W'(player_row_pos));
    col_full = pos_x[POS_W-2:FRAC_BITS];
    row_full = pos_y[POS_W-2:FRAC_BITS];

    // negative positions and rows or columns off the map miss
    row_ok = !pos_y[POS_W-1] && (row_full < RC_W'(row_count)) &&
             (row_full < RC_W'(MAP_ROWS));
    col_ok = !pos_x[POS_W-1] && (col_full < RC_W'(MAP_COLS));

    p_next.mode       = dstage[DIV_STAGES].mode;
    p_next.player_hit = dstage[DIV_STAGES].player_hit;
    p_next.border_hit = dstage[DIV_STAGES].border_hit;
    p_next.cell_ok    = row_ok && col_ok && (cell_pixels != '0);
    p_next.tile_wr_ok = (int'(dstage[DIV_STAGES].map_row) < MAP_ROWS) &&
                        (int'(dstage[DIV_STAGES].map_col) < MAP_COLS);
    p_next.row_wr_ok  = int'(dstage[DIV_STAGES].map_row) < MAP_ROWS;
    p_next.col_idx    = col_full[COL_CW-1:0];
    p_next.cell_code  = dstage[DIV_STAGES].cell_code;
    p_next.row_length = dstage[DIV_STAGES].row_length;

    // loads address the stores by their own fields, queries by the cell found
    if (dstage[DIV_STAGES].mode == MODE_PIXEL) begin
      p_next.tile_addr = TILE_AW'(int'(row_full[ROW_W-1:0]) * MAP_COLS +
                                  int'(col_full[COL_CW-1:0]));
      p_next.row_addr  = row_full[ROW_W-1:0];
    end else begin
      p_next.tile_addr = TILE_AW'(int'(dstage[DIV_STAGES].map_row) * MAP_COLS +
                                  int'(dstage[DIV_STAGES].map_col));
      p_next.row_addr  = ROW_W'(dstage[DIV_STAGES].map_row);
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready) begin
      pst <= p_next;
    end
  end

  // --------------------------------------------------------------------------
  // map stores: a word reads or writes as it leaves the position stage, so
  // loads and queries keep their order; read data holds during a stall
  // --------------------------------------------------------------------------
  logic              tile_we;
  logic              tile_re;
  logic              rlen_we;
  logic [CODE_W-1:0] tile_q;
  logic [LEN_W-1:0]  rlen_q;

  assign tile_we = p_vld && r_ready && (pst.mode == MODE_CELL) && pst.tile_wr_ok;
  assign rlen_we = p_vld && r_ready && (pst.mode == MODE_ROWLEN) && pst.row_wr_ok;
  assign tile_re = p_vld && r_ready && (pst.mode == MODE_PIXEL);

  mmpc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (TILE_DEPTH)
  ) u_tile_ram (
    .clk   (clk),
    .we    (tile_we),
    .waddr (pst.tile_addr),
    .wdata (pst.cell_code),
    .re    (tile_re),
    .raddr (pst.tile_addr),
    .rdata (tile_q)
  );

  mmpc_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAP_ROWS)
  ) u_rlen_ram (
    .clk   (clk),
    .we    (rlen_we),
    .waddr (pst.row_addr),
    .wdata (pst.row_length),
    .re    (tile_re),
    .raddr (pst.row_addr),
    .rdata (rlen_q)
  );

  rd_item_t rd_item;

  // load words end here, only queries go on
  always_ff @(posedge clk) begin
    if (r_ready) begin
      rd_item.player_hit <= pst.player_hit;
      rd_item.border_hit <= pst.border_hit;
      rd_item.cell_ok    <= pst.cell_ok;
      rd_item.col_idx    <= pst.col_idx;
    end
  end

  // --------------------------------------------------------------------------
  // color stage: priority player, map cell, border, background
  // --------------------------------------------------------------------------
  logic                map_hit;
  logic [COLOR_W-1:0]  color_next;
  pixel_class_t        class_next;
  logic [COLOR_W-1:0]  res_color;
  pixel_class_t        res_class;

  always_comb begin
    map_hit = rd_item.cell_ok && (rd_item.col_idx < COL_CW'(rlen_q));
    priority if (rd_item.player_hit) begin
      color_next = COLOR_PLAYER;
      class_next = CLASS_PLAYER;
    end else if (map_hit && (tile_q == TILE_FLOOR)) begin
      color_next = COLOR_FLOOR;
      class_next = CLASS_FLOOR;
    end else if (map_hit && (tile_q == TILE_DOOR)) begin
      color_next = COLOR_DOOR;
      class_next = CLASS_DOOR;
    end else if (rd_item.border_hit) begin
      color_next = COLOR_BORDER;
      class_next = CLASS_BORDER;
    end else begin
      color_next = COLOR_BACK;
      class_next = CLASS_BACK;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      res_color <= color_next;
      res_class <= class_next;
    end
  end

  assign rsp.valid       = res_vld;
  assign rsp.color       = res_color;
  assign rsp.pixel_class = res_class;

  // --------------------------------------------------------------------------
  // valid bits
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dvld    <= '0;
      p_vld   <= 1'b0;
      r_vld   <= 1'b0;
      res_vld <= 1'b0;
    end else begin
      // the unused mode is taken and dropped
      if (dready[0]) begin
        dvld[0] <= req.valid && (req.mode != MODE_UNUSED);
      end
      for (int k = 1; k <= DIV_STAGES; k++) begin
        if (dready[k]) begin
          dvld[k] <= dvld[k-1];
        end
      end
      if (p_ready) begin
        p_vld <= dvld[DIV_STAGES];
      end
      if (r_ready) begin
        r_vld <= p_vld && (pst.mode == MODE_PIXEL);
      end
      if (o_ready) begin
        res_vld <= r_vld;
      end
    end
  end

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // a full pipe behind a stalled result refuses new words
  `MMPC_ASSERT(a_full_stall, ((&dvld) && p_vld && r_vld && res_vld && !rsp.ready) |-> !req.ready)
  // a query that reads the stores reaches the read stage next cycle
  `MMPC_ASSERT_NEXT(a_query_read, tile_re, r_vld)
  // map colors need a nonzero cell size
  `MMPC_ASSERT(a_zero_unit, (r_vld && rd_item.cell_ok) |-> (cell_pixels != '0))
  // a store is never written and read by the same word
  `MMPC_ASSERT(a_one_access, !((tile_we || rlen_we) && tile_re))

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: minimap pixel colorer testbench
// loads map rows and tiles, sweeps pixel queries over several view settings
// and checks every color word against an in-bench color predictor
// ----------------------------------------------------------------------------

module tb_top;
  import mmpc_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  localparam int TAIL_CYCLES  = 24;
  localparam int HOLD_CYCLES  = 400;     // long receiver stall, fills the pipe
  localparam int TIMEOUT_NS   = 4000000;

  // tile codes with no color of their own
  localparam logic [CODE_W-1:0] TILE_OTHER = 2'd0;
  localparam logic [CODE_W-1:0] TILE_SPARE = 2'd3;

  // one request word as the sender offers it
  typedef struct packed {
    mode_t              mode;
    logic [PIX_W-1:0]   pix_x;
    logic [PIX_W-1:0]   pix_y;
    logic [IDX_W-1:0]   map_row;
    logic [IDX_W-1:0]   map_col;
    logic [CODE_W-1:0]  cell_code;
    logic [LEN_W-1:0]   row_length;
  } req_word_t;

  // one expected color word
  typedef struct packed {
    logic [COLOR_W-1:0] color;
    pixel_class_t       cls;
  } color_word_t;

  // view registers as the block holds them
  typedef struct packed {
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   height;
    logic [UNIT_W-1:0]   unit;
    logic [PLAYER_W-1:0] pcol;
    logic [PLAYER_W-1:0] prow;
    logic [COUNT_W-1:0]  rows;
  } view_cfg_t;

  localparam view_cfg_t RESET_VIEW = '{width: 11'd200, height: 11'd200, unit: 7'd10,
                                       pcol: '0, prow: '0, rows: '0};

  logic clk = 1'b0;
  logic rst = 1'b1;

  mmpc_cfg_if cfg_bus ();
  mmpc_req_if pix_req ();
  mmpc_rsp_if pix_rsp ();

  minimap_pixel_color_top u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_bus),
    .req (pix_req),
    .rsp (pix_rsp)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // shared state
  // ---------------------------------------------------------------------------
  req_word_t   words_to_send[$];   // offered in order by the driver
  color_word_t colors_due[$];      // predicted colors, oldest first
  int          words_pushed   = 0;
  int          words_accepted = 0;
  int          mismatches     = 0;

  // idle rates in percent, set per stage by the sequencer
  int src_idle_pct  = 16;
  int sink_idle_pct = 52;

  // long receiver hold, asked by the sequencer and served by the receiver
  int holds_asked = 0;
  int holds_taken = 0;
  int hold_left   = 0;

  logic        req_fired = 1'b0;   // request word taken at the last rising edge
  req_word_t   next_word;
  color_word_t due_word;

  // predictor copy of the registers and map, updated on accepted words only
  view_cfg_t          pred_cfg = RESET_VIEW;
  logic [CODE_W-1:0]  tile_map [TILE_DEPTH];
  logic [LEN_W-1:0]   row_len  [MAP_ROWS];

  // sequencer view of the map: which entries are written, and the row lengths,
  // so no query ever touches an entry still unknown in the block
  view_cfg_t          gen_cfg = RESET_VIEW;
  bit                 tile_known [TILE_DEPTH];
  bit                 row_known  [MAP_ROWS];
  logic [LEN_W-1:0]   gen_row_len[MAP_ROWS];

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // map cell under a pixel; returns 1 when the row is in use, so that the
  // row length is looked at. positions are q.8, the quotient truncates to zero
  function automatic bit cell_under(input view_cfg_t c, input int x, input int y,
                                    output int row, output int col);
    longint unit;
    longint xm;
    longint ym;
    row  = 0;
    col  = 0;
    unit = longint'(c.unit);
    if (unit == 0) begin
      return 1'b0;
    end
    xm = (longint'(x) - longint'(c.width) / 2) * (longint'(1) << FRAC_BITS) / unit
         + longint'(c.pcol);
    ym = (longint'(y) - longint'(c.height) / 2) * (longint'(1) << FRAC_BITS) / unit
         + longint'(c.prow);
    if (xm < 0 || ym < 0) begin
      return 1'b0;
    end
    row = int'(ym >>> FRAC_BITS);
    col = int'(xm >>> FRAC_BITS);
    return (row < int'(c.rows) && row < MAP_ROWS);
  endfunction

  // color of one pixel under the current predictor registers and map
  function automatic color_word_t color_of(input int x, input int y);
    longint            w;
    longint            h;
    longint            u;
    longint            lx;
    longint            ly;
    int                row;
    int                col;
    logic [CODE_W-1:0] code;
    color_word_t       cw;
    w    = longint'(pred_cfg.width);
    h    = longint'(pred_cfg.height);
    u    = longint'(pred_cfg.unit);
    lx   = longint'(x);
    ly   = longint'(y);
    code = TILE_OTHER;
    if (cell_under(pred_cfg, x, y, row, col)) begin
      if (col < int'(row_len[row]) && col < MAP_COLS) begin
        code = tile_map[row * MAP_COLS + col];
      end
    end
    // player square: strict bounds, halves truncate toward zero
    if (ly > (h - u) / 2 && ly < (h + u) / 2 && lx > (w - u) / 2 && lx < (w + u) / 2) begin
      cw = '{color: COLOR_PLAYER, cls: CLASS_PLAYER};
    end else if (code == TILE_FLOOR) begin
      cw = '{color: COLOR_FLOOR, cls: CLASS_FLOOR};
    end else if (code == TILE_DOOR) begin
      cw = '{color: COLOR_DOOR, cls: CLASS_DOOR};
    end else if (lx < BORDER_PIX || lx > w - 1 - BORDER_PIX ||
                 ly < BORDER_PIX || ly > h - 1 - BORDER_PIX) begin
      cw = '{color: COLOR_BORDER, cls: CLASS_BORDER};
    end else begin
      cw = '{color: COLOR_BACK, cls: CLASS_BACK};
    end
    return cw;
  endfunction

  task automatic flag_mismatch(input string what, input logic [COLOR_W-1:0] got,
                               input logic [COLOR_W-1:0] wanted);
    $display("mismatch at %0t: %s got %h wanted %h", $realtime, what, got, wanted);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // driver: next word at the falling edge once the last one was taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pix_req.valid <= 1'b0;
    end else if (!pix_req.valid || req_fired) begin
      if (words_to_send.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        next_word = words_to_send.pop_front();
        pix_req.valid      <= 1'b1;
        pix_req.mode       <= next_word.mode;
        pix_req.pix_x      <= next_word.pix_x;
        pix_req.pix_y      <= next_word.pix_y;
        pix_req.map_row    <= next_word.map_row;
        pix_req.map_col    <= next_word.map_col;
        pix_req.cell_code  <= next_word.cell_code;
        pix_req.row_length <= next_word.row_length;
      end else begin
        pix_req.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random ready, or a long hold when the sequencer asks for one
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pix_rsp.ready <= 1'b0;
    end else if (hold_left > 0) begin
      pix_rsp.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (holds_taken != holds_asked) begin
      pix_rsp.ready <= 1'b0;
      holds_taken   <= holds_asked;
      hold_left     <= HOLD_CYCLES;
    end else begin
      pix_rsp.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: register writes, accepted words and color words at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    req_fired <= pix_req.valid && pix_req.ready;
    if (rst) begin
      pred_cfg = RESET_VIEW;
    end else begin
      // register writes land in the predictor copy
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_reg_t'(cfg_bus.index))
          REG_VIEW_WIDTH:  pred_cfg.width  = cfg_bus.data[SIZE_W-1:0];
          REG_VIEW_HEIGHT: pred_cfg.height = cfg_bus.data[SIZE_W-1:0];
          REG_CELL_PIXELS: pred_cfg.unit   = cfg_bus.data[UNIT_W-1:0];
          REG_PLAYER_COL:  pred_cfg.pcol   = cfg_bus.data[PLAYER_W-1:0];
          REG_PLAYER_ROW:  pred_cfg.prow   = cfg_bus.data[PLAYER_W-1:0];
          REG_ROW_COUNT:   pred_cfg.rows   = cfg_bus.data[COUNT_W-1:0];
          default: ;
        endcase
      end
      // load words update the map, pixel words queue a predicted color
      if (pix_req.valid && pix_req.ready) begin
        words_accepted++;
        case (mode_t'(pix_req.mode))
          MODE_CELL:   tile_map[pix_req.map_row * MAP_COLS + pix_req.map_col] = pix_req.cell_code;
          MODE_ROWLEN: row_len[pix_req.map_row] = pix_req.row_length;
          MODE_PIXEL:  colors_due.push_back(color_of(int'(pix_req.pix_x), int'(pix_req.pix_y)));
          default: ;
        endcase
      end
      // each color word against the oldest prediction, field by field
      if (pix_rsp.valid && pix_rsp.ready) begin
        if (colors_due.size() == 0) begin
          flag_mismatch("color word with none due", pix_rsp.color, '0);
        end else begin
          due_word = colors_due.pop_front();
          if (pix_rsp.color !== due_word.color) begin
            flag_mismatch("color", pix_rsp.color, due_word.color);
          end
          if (pix_rsp.pixel_class !== due_word.cls) begin
            flag_mismatch("pixel_class", COLOR_W'(pix_rsp.pixel_class), COLOR_W'(due_word.cls));
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // word builders, all called from the sequencer
  // ---------------------------------------------------------------------------

  // fields that the mode does not use carry random noise
  function automatic req_word_t rand_word();
    req_word_t w;
    w.mode       = MODE_UNUSED;
    w.pix_x      = PIX_W'($urandom_range(0, 1023));
    w.pix_y      = PIX_W'($urandom_range(0, 1023));
    w.map_row    = IDX_W'($urandom_range(0, 63));
    w.map_col    = IDX_W'($urandom_range(0, 63));
    w.cell_code  = CODE_W'($urandom_range(0, 3));
    w.row_length = LEN_W'($urandom_range(0, 64));
    return w;
  endfunction

  function automatic logic [CODE_W-1:0] pick_code();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return TILE_FLOOR;
    if (r < 8) return TILE_DOOR;
    if (r == 8) return TILE_OTHER;
    return TILE_SPARE;
  endfunction

  function automatic int clamp_pix(input int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  task automatic push_word(input req_word_t w);
    words_to_send.push_back(w);
    words_pushed++;
  endtask

  task automatic send_tile(input int row, input int col, input logic [CODE_W-1:0] code);
    req_word_t w;
    w           = rand_word();
    w.mode      = MODE_CELL;
    w.map_row   = IDX_W'(row);
    w.map_col   = IDX_W'(col);
    w.cell_code = code;
    tile_known[row * MAP_COLS + col] = 1'b1;
    push_word(w);
  endtask

  task automatic send_row_len(input int row, input int len);
    req_word_t w;
    w            = rand_word();
    w.mode       = MODE_ROWLEN;
    w.map_row    = IDX_W'(row);
    w.row_length = LEN_W'(len);
    row_known[row]   = 1'b1;
    gen_row_len[row] = LEN_W'(len);
    push_word(w);
  endtask

  task automatic send_ignored();
    req_word_t w;
    w      = rand_word();
    w.mode = MODE_UNUSED;
    push_word(w);
  endtask

  // a query, preceded by whatever map loads it needs so nothing unknown is read
  task automatic send_query(input int x, input int y);
    req_word_t w;
    int        row;
    int        col;
    if (cell_under(gen_cfg, x, y, row, col)) begin
      if (!row_known[row]) begin
        send_row_len(row, ($urandom_range(0, 9) < 7) ? MAP_COLS : int'($urandom_range(0, 64)));
      end
      if (col < int'(gen_row_len[row]) && col < MAP_COLS) begin
        if (!tile_known[row * MAP_COLS + col]) begin
          send_tile(row, col, pick_code());
        end
      end
    end
    w       = rand_word();
    w.mode  = MODE_PIXEL;
    w.pix_x = PIX_W'(x);
    w.pix_y = PIX_W'(y);
    push_word(w);
  endtask

  // ---------------------------------------------------------------------------
  // register writes, only while the block is idle
  // ---------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_W'(value);
    do begin
      @(posedge clk);
    end while (!cfg_bus.ready);
    @(negedge clk);
  endtask

  task automatic write_view(input view_cfg_t c);
    write_reg(REG_VIEW_WIDTH,  int'(c.width));
    write_reg(REG_VIEW_HEIGHT, int'(c.height));
    write_reg(REG_CELL_PIXELS, int'(c.unit));
    write_reg(REG_PLAYER_COL,  int'(c.pcol));
    write_reg(REG_PLAYER_ROW,  int'(c.prow));
    write_reg(REG_ROW_COUNT,   int'(c.rows));
    cfg_bus.valid <= 1'b0;
    gen_cfg = c;
  endtask

  function automatic view_cfg_t make_view(input int w, input int h, input int u,
                                          input int pc, input int pr, input int rc);
    view_cfg_t v;
    v.width  = SIZE_W'(w);
    v.height = SIZE_W'(h);
    v.unit   = UNIT_W'(u);
    v.pcol   = PLAYER_W'(pc);
    v.prow   = PLAYER_W'(pr);
    v.rows   = COUNT_W'(rc);
    return v;
  endfunction

  // wait for every offered word to be taken and every color to arrive, then
  // let trailing map writes settle
  task automatic drain();
    while (words_accepted != words_pushed || colors_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  // random mix: mostly queries over the view, some near the player square,
  // plus map rewrites and ignored words as noise
  task automatic run_random(input int count);
    int done;
    int r;
    int span_x;
    int cx;
    int cy;
    int u;
    done = 0;
    while (done < count) begin
      r      = $urandom_range(0, 99);
      span_x = (int'(gen_cfg.width) > 1024) ? 1024 : int'(gen_cfg.width);
      cx     = int'(gen_cfg.width) / 2;
      cy     = int'(gen_cfg.height) / 2;
      u      = int'(gen_cfg.unit);
      if (r < 62) begin
        if ($urandom_range(0, 99) < 85) begin
          send_query(int'($urandom_range(0, span_x - 1)),
                     clamp_pix(int'($urandom_range(0, int'(gen_cfg.height) - 1))));
        end else begin
          send_query(int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)));
        end
      end else if (r < 72) begin
        // around the player square edges
        send_query(clamp_pix(cx - u / 2 - 2 + int'($urandom_range(0, u + 4))),
                   clamp_pix(cy - u / 2 - 2 + int'($urandom_range(0, u + 4))));
      end else if (r < 82) begin
        send_tile(int'($urandom_range(0, 63)), int'($urandom_range(0, 63)), pick_code());
      end else if (r < 90) begin
        send_row_len(int'($urandom_range(0, 63)), int'($urandom_range(0, 64)));
      end else if (r < 95) begin
        send_query(clamp_pix(cx + int'($urandom_range(0, 8)) - 4), int'($urandom_range(0, 1023)));
      end else begin
        send_ignored();
        continue;   // ignored words do not count
      end
      done++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  initial begin
    pix_req.valid      = 1'b0;
    pix_req.mode       = MODE_PIXEL;
    pix_req.pix_x      = '0;
    pix_req.pix_y      = '0;
    pix_req.map_row    = '0;
    pix_req.map_col    = '0;
    pix_req.cell_code  = '0;
    pix_req.row_length = '0;
    pix_rsp.ready      = 1'b0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = REG_VIEW_WIDTH;
    cfg_bus.data       = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles now and then, receiver about half the time
    src_idle_pct  = 16;
    sink_idle_pct = 52;

    // directed: reset view, no rows in use, so no query hits the map yet
    send_row_len(0, 64);
    send_row_len(63, 0);
    send_tile(0, 0, TILE_OTHER);
    send_tile(0, 1, TILE_FLOOR);
    send_tile(0, 2, TILE_DOOR);
    send_tile(0, 3, TILE_SPARE);
    send_tile(63, 63, TILE_FLOOR);
    send_ignored();
    send_query(0, 0);
    send_query(1023, 1023);
    send_query(1023, 0);
    send_query(0, 1023);
    send_query(100, 100);    // player center
    send_query(95, 100);     // just outside the strict lower bound
    send_query(96, 96);      // first pixel inside
    send_query(104, 104);    // last pixel inside
    send_query(105, 100);    // just outside the upper bound
    send_query(1, 50);       // border, left
    send_query(2, 50);       // first inner column
    send_query(197, 50);     // last inner column
    send_query(198, 50);     // border, right
    send_query(50, 50);      // background
    drain();

    // centered player over a full map, with one long receiver hold
    write_view(make_view(200, 200, 10, 32 * 256, 32 * 256, 64));
    holds_asked++;
    run_random(300);
    drain();

    // smallest view and cell, player at the origin so many positions go negative
    write_view(make_view(8, 8, 1, 0, 0, 1));
    run_random(100);
    drain();

    // largest view and cell, player at the far corner
    write_view(make_view(1024, 1024, 64, 16383, 16383, 64));
    run_random(150);
    drain();

    // now the other way round: sender idles about half the time
    src_idle_pct  = 52;
    sink_idle_pct = 16;

    // zero cell size: never a map hit, never a player square
    write_view(make_view(300, 120, 0, 2688, 1344, 64));
    run_random(60);
    drain();

    // odd cell size for truncation; sender pauses midway until all colors are in
    write_view(make_view(640, 480, 7, int'($urandom_range(0, 16383)),
                         int'($urandom_range(0, 12000)), 40));
    run_random(125);
    drain();
    run_random(125);
    drain();

    // cell wider than the view height, no rows in use
    write_view(make_view(1024, 8, 64, 640, 256, 0));
    run_random(60);
    drain();

    // neither side idles
    src_idle_pct  = 0;
    sink_idle_pct = 0;

    write_view(make_view(9, 1023, 3, 256, 60 * 256, 64));
    run_random(150);
    drain();

    repeat (2) begin
      write_view(make_view(int'($urandom_range(8, 1024)), int'($urandom_range(8, 1024)),
                           int'($urandom_range(1, 64)), int'($urandom_range(0, 16383)),
                           int'($urandom_range(0, 16383)), int'($urandom_range(0, 64))));
      run_random(100);
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS minimap_pixel_color_top");
    end else begin
      $display("FAIL minimap_pixel_color_top");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL minimap_pixel_color_top");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/mmpc_pkg.sv
rtl/mmpc_req_if.sv
rtl/mmpc_rsp_if.sv
rtl/mmpc_cfg_if.sv
rtl/mmpc_ram.sv
rtl/minimap_pixel_color_top.sv
tb/sv/tb_top.sv
